[src/spind_pkg.sv]
package spind_pkg;

  // Field widths
  localparam int IDX_W      = 6;
  localparam int HALF_W     = 32;
  localparam int CPLX_W     = 2 * HALF_W;
  localparam int K_W        = 7;    // signed wavenumber, covers -64..63
  localparam int KSQ_W      = 14;   // |k|^2 <= 3 * 64^2
  localparam int COEF_W     = 46;   // eta * |k|^2
  localparam int CURL_W     = 41;   // component of i k x C
  localparam int DAMP_W     = 62;   // |eta*|k|^2*b| after the 16 bit shift
  localparam int RATE_W     = 64;
  localparam int SMAG_W     = 41;   // step magnitude, capped at 2^40

  localparam int NUM_COMP    = 3;
  localparam int NUM_SCALARS = 2 * NUM_COMP;

  // Stream widths
  localparam int IN_FIELDS_W = 3 * IDX_W + 2 * NUM_COMP * CPLX_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = NUM_COMP * CPLX_W;

  // Pipeline split
  localparam int FRONT_STAGES = 3;
  localparam int LANE_STAGES  = 7;
  localparam int NUM_STAGES   = FRONT_STAGES + LANE_STAGES;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd1;

  localparam logic [HALF_W-1:0] DIFFUSIVITY_RST = 32'd655;
  localparam logic [HALF_W-1:0] TIME_STEP_RST   = 32'd42950;

  // Rounding offsets and caps
  localparam logic [77:0] ROUND_DAMP = 78'd32768;
  localparam logic [95:0] ROUND_STEP = 96'h8000_0000;
  localparam logic [RATE_W-1:0] STEP_CAP = 64'h0000_0100_0000_0000;

  typedef logic signed [HALF_W-1:0] half_t;
  typedef logic signed [K_W-1:0]    k_t;
  typedef logic signed [CURL_W-1:0] curl_t;
  typedef logic [COEF_W-1:0]        coef_t;

endpackage

[src/spectral_induction_mode_update.sv]
// Channel | Direction | Handshake            | Payload
// in_     | in        | in_tvalid/in_tready   | in_tdata: indices, B, u x B
// out_    | out       | out_tvalid/out_tready | out_tdata: updated B
// cfg_    | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One request per cycle while in_tready is high; a result passes through the ten
// register stages (three in the front end, seven per lane, two of them carrying
// the partial products of the split damping and time-step multiplies).
// Reset clears all stage valid bits and reloads diffusivity and time step.
// A stalled output holds the last stage and the unbroken run of full stages behind
// it; empty stages ahead keep filling, and in_tready drops only when every stage holds a request.
module spectral_induction_mode_update #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, lowest bit up: index_x, index_y, index_z, field_x, field_y,
  // field_z, drive_x, drive_y, drive_z, zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spind_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, lowest bit up: new_field_x, new_field_y, new_field_z
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spind_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spind_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spind_pkg::HALF_W-1:0]        cfg_data
);
  import spind_pkg::*;

  localparam int FIELD_LSB = 3 * IDX_W;
  localparam int DRIVE_LSB = FIELD_LSB + NUM_COMP * CPLX_W;

  // Configuration registers
  logic [HALF_W-1:0] diffusivity_r;
  logic [HALF_W-1:0] time_step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diffusivity_r <= DIFFUSIVITY_RST;
      time_step_r   <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIFFUSIVITY: diffusivity_r <= cfg_data;
        CFG_TIME_STEP:   time_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids and bubble-collapsing enables
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = ~v_r[NUM_STAGES-1] | out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NUM_STAGES-1];

  // Unpack request
  logic [CPLX_W-1:0] field [NUM_COMP];
  logic [CPLX_W-1:0] drive [NUM_COMP];

  always_comb begin
    for (int n = 0; n < NUM_COMP; n++) begin
      field[n] = in_tdata[FIELD_LSB + n*CPLX_W +: CPLX_W];
      drive[n] = in_tdata[DRIVE_LSB + n*CPLX_W +: CPLX_W];
    end
  end

  // Front end: wavenumbers, curl, |k|^2, damping coefficient
  half_t             b_f    [NUM_SCALARS];
  logic [HALF_W-1:0] bmag_f [NUM_SCALARS];
  curl_t             c_f    [NUM_SCALARS];
  coef_t             coef_f;

  spind_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk         (clk),
    .en          (en[FRONT_STAGES-1:0]),
    .index_x     (in_tdata[IDX_W-1:0]),
    .index_y     (in_tdata[2*IDX_W-1:IDX_W]),
    .index_z     (in_tdata[3*IDX_W-1:2*IDX_W]),
    .field       (field),
    .drive       (drive),
    .diffusivity (diffusivity_r),
    .b_o         (b_f),
    .bmag_o      (bmag_f),
    .c_o         (c_f),
    .coef_o      (coef_f)
  );

  // One lane per real scalar
  half_t res [NUM_SCALARS];

  for (genvar s = 0; s < NUM_SCALARS; s++) begin : g_lane
    spind_lane u_lane (
      .clk       (clk),
      .en        (en[NUM_STAGES-1:FRONT_STAGES]),
      .b_i       (b_f[s]),
      .bmag_i    (bmag_f[s]),
      .c_i       (c_f[s]),
      .coef_i    (coef_f),
      .time_step (time_step_r),
      .res_o     (res[s])
    );
  end

  // Pack result: re in the high half of each component
  always_comb begin
    for (int n = 0; n < NUM_COMP; n++) begin
      out_tdata[n*CPLX_W +: CPLX_W] = {res[2*n], res[2*n+1]};
    end
  end

`ifndef ASSERT_OFF
  // Requests in flight change only by what enters and leaves
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(v_r) == $past($countones(v_r))
      + int'($past(in_tvalid && in_tready)) - int'($past(out_tvalid && out_tready)))
    else $error("stage valid count out of step with requests");

  // Full pipeline behind a stalled output takes nothing new
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_tready) |-> !in_tready)
    else $error("request taken into a full stalled pipeline");

  // An empty first stage always takes a request
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_tready)
    else $error("in_tready low with first stage empty");

  // A taken request occupies the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("taken request lost at pipeline entry");
`endif

endmodule

[src/spind_front.sv]
module spind_front #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                  clk,
  input  logic [spind_pkg::FRONT_STAGES-1:0]    en,
  input  logic [spind_pkg::IDX_W-1:0]           index_x,
  input  logic [spind_pkg::IDX_W-1:0]           index_y,
  input  logic [spind_pkg::IDX_W-1:0]           index_z,
  input  logic [spind_pkg::CPLX_W-1:0]          field [spind_pkg::NUM_COMP],
  input  logic [spind_pkg::CPLX_W-1:0]          drive [spind_pkg::NUM_COMP],
  input  logic [spind_pkg::HALF_W-1:0]          diffusivity,
  output spind_pkg::half_t                      b_o    [spind_pkg::NUM_SCALARS],
  output logic [spind_pkg::HALF_W-1:0]          bmag_o [spind_pkg::NUM_SCALARS],
  output spind_pkg::curl_t                      c_o    [spind_pkg::NUM_SCALARS],
  output spind_pkg::coef_t                      coef_o
);
  import spind_pkg::*;

  localparam int NUM_IDX = 2 ** IDX_W;

  // Index to signed wavenumber, worked out at elaboration
  k_t kmap [NUM_IDX];
  for (genvar w = 0; w < NUM_IDX; w++) begin : g_kmap
    localparam int RED  = w % GRID_SIZE;
    localparam int WAVE = (RED > GRID_SIZE / 2) ? RED - GRID_SIZE : RED;
    assign kmap[w] = K_W'(WAVE);
  end

  // Stage 0: wavenumbers and unpacked halves
  k_t    k0_r [NUM_COMP];
  half_t b0_r [NUM_SCALARS];
  half_t d0_r [NUM_SCALARS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k0_r[0] <= kmap[index_x];
      k0_r[1] <= kmap[index_y];
      k0_r[2] <= k_t'({1'b0, index_z});
      for (int n = 0; n < NUM_COMP; n++) begin
        b0_r[2*n]   <= field[n][CPLX_W-1:HALF_W];
        b0_r[2*n+1] <= field[n][HALF_W-1:0];
        d0_r[2*n]   <= drive[n][CPLX_W-1:HALF_W];
        d0_r[2*n+1] <= drive[n][HALF_W-1:0];
      end
    end
  end

  // Stage 1: curl i k x C, |k|^2 and field magnitudes
  curl_t            c1_nxt    [NUM_SCALARS];
  logic [HALF_W-1:0] bmag1_nxt [NUM_SCALARS];
  logic [KSQ_W-1:0] ksq1_nxt;

  always_comb begin
    int    p;
    int    q;
    int    sq;
    curl_t are;
    curl_t aim;
    for (int n = 0; n < NUM_COMP; n++) begin
      p = (n == NUM_COMP - 1) ? 0 : n + 1;
      q = (n == 0) ? NUM_COMP - 1 : n - 1;
      are = k0_r[p] * d0_r[2*q]   - k0_r[q] * d0_r[2*p];
      aim = k0_r[p] * d0_r[2*q+1] - k0_r[q] * d0_r[2*p+1];
      // i*a: real part is -Im(a), imaginary part is Re(a)
      c1_nxt[2*n]   = -aim;
      c1_nxt[2*n+1] = are;
    end
    sq = int'(k0_r[0]) * int'(k0_r[0]) + int'(k0_r[1]) * int'(k0_r[1])
       + int'(k0_r[2]) * int'(k0_r[2]);
    ksq1_nxt = KSQ_W'(sq);
    for (int s = 0; s < NUM_SCALARS; s++) begin
      bmag1_nxt[s] = b0_r[s][HALF_W-1] ? (~b0_r[s] + 1'b1) : b0_r[s];
    end
  end

  half_t             b1_r    [NUM_SCALARS];
  logic [HALF_W-1:0] bmag1_r [NUM_SCALARS];
  curl_t             c1_r    [NUM_SCALARS];
  logic [KSQ_W-1:0]  ksq1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b1_r    <= b0_r;
      bmag1_r <= bmag1_nxt;
      c1_r    <= c1_nxt;
      ksq1_r  <= ksq1_nxt;
    end
  end

  // Stage 2: damping coefficient eta*|k|^2
  coef_t coef2_nxt;
  assign coef2_nxt = COEF_W'(diffusivity) * COEF_W'(ksq1_r);

  half_t             b2_r    [NUM_SCALARS];
  logic [HALF_W-1:0] bmag2_r [NUM_SCALARS];
  curl_t             c2_r    [NUM_SCALARS];
  coef_t             coef2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b2_r    <= b1_r;
      bmag2_r <= bmag1_r;
      c2_r    <= c1_r;
      coef2_r <= coef2_nxt;
    end
  end

  assign b_o    = b2_r;
  assign bmag_o = bmag2_r;
  assign c_o    = c2_r;
  assign coef_o = coef2_r;

endmodule

[src/spind_lane.sv]
module spind_lane (
  input  logic                               clk,
  input  logic [spind_pkg::LANE_STAGES-1:0]  en,
  input  spind_pkg::half_t                   b_i,
  input  logic [spind_pkg::HALF_W-1:0]       bmag_i,
  input  spind_pkg::curl_t                   c_i,
  input  spind_pkg::coef_t                   coef_i,
  input  logic [spind_pkg::HALF_W-1:0]       time_step,
  output spind_pkg::half_t                   res_o
);
  import spind_pkg::*;

  localparam int COEF_HI_W = COEF_W - HALF_W;

  // L0: coef * |b| as two partial products
  logic [CPLX_W-1:0]           plo0_nxt;
  logic [COEF_HI_W+HALF_W-1:0] phi0_nxt;
  assign plo0_nxt = CPLX_W'(coef_i[HALF_W-1:0]) * CPLX_W'(bmag_i);
  assign phi0_nxt = (COEF_HI_W + HALF_W)'(coef_i[COEF_W-1:HALF_W])
                  * (COEF_HI_W + HALF_W)'(bmag_i);

  logic [CPLX_W-1:0]           plo0_r;
  logic [COEF_HI_W+HALF_W-1:0] phi0_r;
  half_t                       b0_r;
  curl_t                       c0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo0_r <= plo0_nxt;
      phi0_r <= phi0_nxt;
      b0_r   <= b_i;
      c0_r   <= c_i;
    end
  end

  // L1: join partial products, round half up on the magnitude
  logic [77:0]       dsum;
  logic [DAMP_W-1:0] r1_nxt;
  assign dsum   = {phi0_r, {HALF_W{1'b0}}} + 78'(plo0_r) + ROUND_DAMP;
  assign r1_nxt = dsum[77:16];

  logic [DAMP_W-1:0] r1_r;
  half_t             b1_r;
  curl_t             c1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_r <= r1_nxt;
      b1_r <= b0_r;
      c1_r <= c0_r;
    end
  end

  // L2: rate = curl - damping, sign of damping follows b
  logic signed [RATE_W-1:0] cx;
  logic signed [RATE_W-1:0] rx;
  logic signed [RATE_W-1:0] rate2_nxt;
  assign cx        = RATE_W'(c1_r);
  assign rx        = RATE_W'(signed'({1'b0, r1_r}));
  assign rate2_nxt = b1_r[HALF_W-1] ? (cx + rx) : (cx - rx);

  logic signed [RATE_W-1:0] rate2_r;
  half_t                    b2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rate2_r <= rate2_nxt;
      b2_r    <= b1_r;
    end
  end

  // L3: sign and magnitude of the rate
  logic [RATE_W-1:0] rmag3_nxt;
  assign rmag3_nxt = rate2_r[RATE_W-1] ? (~rate2_r + 1'b1) : rate2_r;

  logic [RATE_W-1:0] rmag3_r;
  logic              rneg3_r;
  half_t             b3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rmag3_r <= rmag3_nxt;
      rneg3_r <= rate2_r[RATE_W-1];
      b3_r    <= b2_r;
    end
  end

  // L4: |rate| * tau as two partial products
  logic [CPLX_W-1:0] qhi4_nxt;
  logic [CPLX_W-1:0] qlo4_nxt;
  assign qhi4_nxt = CPLX_W'(rmag3_r[RATE_W-1:HALF_W]) * CPLX_W'(time_step);
  assign qlo4_nxt = CPLX_W'(rmag3_r[HALF_W-1:0]) * CPLX_W'(time_step);

  logic [CPLX_W-1:0] qhi4_r;
  logic [CPLX_W-1:0] qlo4_r;
  logic              rneg4_r;
  half_t             b4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      qhi4_r  <= qhi4_nxt;
      qlo4_r  <= qlo4_nxt;
      rneg4_r <= rneg3_r;
      b4_r    <= b3_r;
    end
  end

  // L5: shift by 32 with rounding, cap the step magnitude
  logic [95:0]       ssum;
  logic [RATE_W-1:0] sfull;
  logic [SMAG_W-1:0] smag5_nxt;
  assign ssum      = {qhi4_r, {HALF_W{1'b0}}} + 96'(qlo4_r) + ROUND_STEP;
  assign sfull     = ssum[95:HALF_W];
  assign smag5_nxt = (sfull > STEP_CAP) ? STEP_CAP[SMAG_W-1:0] : sfull[SMAG_W-1:0];

  logic [SMAG_W-1:0] smag5_r;
  logic              rneg5_r;
  half_t             b5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      smag5_r <= smag5_nxt;
      rneg5_r <= rneg4_r;
      b5_r    <= b4_r;
    end
  end

  // L6: apply sign, add to field, saturate to Q16.16
  logic signed [SMAG_W+1:0] sv;
  logic signed [SMAG_W+1:0] vsum;
  half_t                    res6_nxt;

  always_comb begin
    sv   = signed'((SMAG_W + 2)'(smag5_r));
    if (rneg5_r) begin
      sv = -sv;
    end
    vsum = sv + (SMAG_W + 2)'(b5_r);
    if ((&vsum[SMAG_W+1:HALF_W-1]) || !(|vsum[SMAG_W+1:HALF_W-1])) begin
      res6_nxt = vsum[HALF_W-1:0];
    end else if (vsum[SMAG_W+1]) begin
      res6_nxt = {1'b1, {(HALF_W-1){1'b0}}};
    end else begin
      res6_nxt = {1'b0, {(HALF_W-1){1'b1}}};
    end
  end

  half_t res6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      res6_r <= res6_nxt;
    end
  end

  assign res_o = res6_r;

endmodule
